FILE: sv/lru_pkg.sv
`default_nettype none

package lru_pkg;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_VICTIM = 2'd1;
    localparam logic [1:0] ACT_ERASE  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY,
        ST_POP
    } state_t;

endpackage

`default_nettype wire

FILE: sv/lru_replacer_unit.sv
// Least-recently-used list of up to ENTRIES keys, held in recency order in a
// circular buffer in one key RAM (one write and one registered read per
// cycle). Issue a beat with start while busy is low; exactly one result beat
// follows, shown on ok, victim_key and count for the single cycle that done
// is high, and it must be taken then. A victim beat reads the head key in
// ST_POP. An insert or erase walks the stored keys one RAM read per cycle in
// ST_SCAN and closes any gap as it goes, then settles the count and, for an
// insert with room, writes the key in ST_APPLY. An undefined action, or a
// victim on an empty list, answers in the next cycle. busy drops in the cycle
// done rises, so the next beat may be issued while a result is shown. No
// clearing pass runs after reset.
`default_nettype none

module lru_replacer_unit #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     action,
    input  wire logic [KEY_BITS-1:0]            key,
    output logic                                done,
    output logic                                ok,
    output logic      [KEY_BITS-1:0]            victim_key,
    output logic      [$clog2(ENTRIES+1)-1:0]   count
);

    import lru_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(ENTRIES);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(ENTRIES - 1);

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_X)
        begin
            sum = sum - DEPTH_X;
        end
        return sum[IDX_W-1:0];
    endfunction

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic               done_reg, done_next;

    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   cur_phys_reg, cur_phys_next;
    logic [IDX_W-1:0]   prev_phys_reg, prev_phys_next;
    logic               found_reg, found_next;
    logic [1:0]         op_reg, op_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic               ok_reg, ok_next;
    logic [KEY_BITS-1:0] victim_reg, victim_next;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    logic [IDX_W-1:0]   next_j;
    logic [IDX_W-1:0]   next_phys;
    logic [IDX_W-1:0]   last_j;
    logic [CNT_W-1:0]   cnt_after;
    logic               hit;

    lru_key_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (KEY_BITS)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign next_j    = j_reg + 1'b1;
    assign next_phys = wrap_add(head_reg, next_j);
    assign last_j    = IDX_W'(count_reg - 1'b1);
    assign cnt_after = count_reg - CNT_W'(found_reg);
    assign hit       = (ram_rdata == key_reg) && !found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg         <= j_next;
        cur_phys_reg  <= cur_phys_next;
        prev_phys_reg <= prev_phys_next;
        found_reg     <= found_next;
        op_reg        <= op_next;
        key_reg       <= key_next;
        ok_reg        <= ok_next;
        victim_reg    <= victim_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        done_next      = 1'b0;
        j_next         = j_reg;
        cur_phys_next  = cur_phys_reg;
        prev_phys_next = prev_phys_reg;
        found_next     = found_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        ok_next        = ok_reg;
        victim_next    = victim_reg;
        ram_we         = 1'b0;
        ram_waddr      = prev_phys_reg;
        ram_wdata      = ram_rdata;
        ram_raddr      = head_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next       = action;
                    key_next      = key;
                    found_next    = 1'b0;
                    j_next        = '0;
                    cur_phys_next = head_reg;
                    case (action)
                        ACT_INSERT, ACT_ERASE:
                        begin
                            state_next = (count_reg == '0) ? ST_APPLY : ST_SCAN;
                        end
                        ACT_VICTIM:
                        begin
                            if (count_reg != '0)
                            begin
                                state_next = ST_POP;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                ok_next     = 1'b0;
                                victim_next = '0;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            ok_next     = 1'b0;
                            victim_next = '0;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                // shift each key after the match down one slot, trailing the reads
                ram_raddr      = next_phys;
                ram_we         = found_reg;
                ram_waddr      = prev_phys_reg;
                ram_wdata      = ram_rdata;
                found_next     = found_reg | hit;
                prev_phys_next = cur_phys_reg;
                cur_phys_next  = next_phys;
                j_next         = next_j;
                if (j_reg == last_j)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                done_next   = 1'b1;
                victim_next = '0;
                state_next  = ST_IDLE;
                if (op_reg == ACT_ERASE)
                begin
                    count_next = cnt_after;
                    ok_next    = found_reg;
                end
                else if (cnt_after != FULL_CNT)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = wrap_add(head_reg, cnt_after[IDX_W-1:0]);
                    ram_wdata  = key_reg;
                    count_next = cnt_after + 1'b1;
                    ok_next    = 1'b1;
                end
                else
                begin
                    ok_next = 1'b0;
                end
            end
            ST_POP:
            begin
                victim_next = ram_rdata;
                head_next   = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
                count_next  = count_reg - 1'b1;
                ok_next     = 1'b1;
                done_next   = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign ok         = ok_reg;
    assign victim_key = victim_reg;
    assign count      = count_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("key count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (count_reg != '0) && (j_reg <= last_j))
        else $error("scan index outside held keys");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |=> done_reg && ok_reg && (count_reg == $past(count_reg) - 1'b1))
        else $error("victim pop did not drop one key");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |=> (count_reg == $past(count_reg)) && !done_reg)
        else $error("count or result changed during scan");

endmodule

`default_nettype wire

FILE: sv/lru_key_ram.sv
`default_nettype none

module lru_key_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
